[rtl/ts_pid_continuity_monitor_assert.svh]
// Assertion macros used by the checker file of the continuity monitor.
`ifndef TS_PID_CONTINUITY_MONITOR_ASSERT_SVH
`define TS_PID_CONTINUITY_MONITOR_ASSERT_SVH

// Same-cycle implication, suspended while reset is high.
`define TSPCM_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, suspended while reset is high.
`define TSPCM_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TSPCM_ASSERT_RESET(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[rtl/tspcm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tspcm_pkg;

  // Field widths of the header beat and of the result beat.
  localparam int PID_WIDTH = 13;
  localparam int CC_WIDTH  = 4;
  localparam int OUT_WIDTH = 32;

  // Defaults for the top-level parameters.
  localparam int PID_SPACE_DEFAULT   = 8192;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Operation codes.
  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Header constants.
  localparam logic [7:0]           SYNC_VALUE      = 8'h47;
  localparam int                   DISC_BIT        = 7;
  localparam int                   AFC_PAYLOAD_BIT = 0;
  localparam int                   AFC_FIELD_BIT   = 1;
  localparam logic [PID_WIDTH-1:0] NULL_PID        = 13'd8191;

  // A classified item as it travels from the front to the back.
  typedef struct packed {
    logic                 is_packet;
    logic                 is_clear;
    logic                 header_ok;
    logic                 check_cc;
    logic                 in_table;
    logic [PID_WIDTH-1:0] pid;
    logic [CC_WIDTH-1:0]  cc;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/ts_pid_continuity_monitor.sv]
// Transport-stream PID continuity monitor.
// Input channel: one beat per item on in_valid/in_stall, carrying op and the
// decoded header fields. op 0 is a packet header, op 1 clears the global
// counts, op 2 (and 3) queries the counts of the pid field.
// Output channel: one result beat per item on out_valid/out_stall, in order.
// Configuration: cfg_write_en with cfg_write_data sets pid_count_enable.
// An accepted beat goes through the command queue, the execute slot with its
// table read, and the result register. A new item enters the slot only once
// the last has left it, after the read and then the write of the per-PID
// table, which has one read and one write port. A two-entry command queue
// sits between the header classifier and the table unit, and the result sits
// in its own register, so input beats are still taken while a result waits
// on a stalled receiver. Reset clears the global counts and disables per-PID
// counting. Turning per-PID counting on clears the table in a sweep over all
// PID_SPACE entries, during which in_stall is high.
// While out_stall is high the result beat holds; the queue then fills and
// in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module ts_pid_continuity_monitor #(
  parameter int PID_SPACE   = tspcm_pkg::PID_SPACE_DEFAULT,
  parameter int COUNT_WIDTH = tspcm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire logic                            cfg_write_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      op,
  input  wire logic [7:0]                      sync_byte,
  input  wire logic                            tei,
  input  wire logic [tspcm_pkg::PID_WIDTH-1:0] pid,
  input  wire logic [1:0]                      afc,
  input  wire logic [tspcm_pkg::CC_WIDTH-1:0]  cc,
  input  wire logic [7:0]                      af_length,
  input  wire logic [7:0]                      af_flags,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 header_ok,
  output logic                                 discontinuity,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      pid_packet_count,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      pid_error_count,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      total_packets,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      bad_packets,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      discontinuities
);

  logic            push;
  tspcm_pkg::cmd_t push_cmd;
  logic            pop;
  logic            head_valid;
  tspcm_pkg::cmd_t head_cmd;
  logic            queue_full;
  logic            clearing;

  // Header classifier.
  tspcm_front #(
    .PID_SPACE (PID_SPACE)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .sync_byte  (sync_byte),
    .tei        (tei),
    .pid        (pid),
    .afc        (afc),
    .cc         (cc),
    .af_length  (af_length),
    .af_flags   (af_flags),
    .queue_full (queue_full),
    .clearing   (clearing),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Command queue.
  tspcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (queue_full)
  );

  // Table and counter unit.
  tspcm_back #(
    .PID_SPACE   (PID_SPACE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .head_valid       (head_valid),
    .head_cmd         (head_cmd),
    .pop              (pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .header_ok        (header_ok),
    .discontinuity    (discontinuity),
    .pid_packet_count (pid_packet_count),
    .pid_error_count  (pid_error_count),
    .total_packets    (total_packets),
    .bad_packets      (bad_packets),
    .discontinuities  (discontinuities)
  );

endmodule

`default_nettype wire

[rtl/tspcm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tspcm_front #(
  parameter int PID_SPACE = tspcm_pkg::PID_SPACE_DEFAULT
) (
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      op,
  input  wire logic [7:0]                      sync_byte,
  input  wire logic                            tei,
  input  wire logic [tspcm_pkg::PID_WIDTH-1:0] pid,
  input  wire logic [1:0]                      afc,
  input  wire logic [tspcm_pkg::CC_WIDTH-1:0]  cc,
  input  wire logic [7:0]                      af_length,
  input  wire logic [7:0]                      af_flags,
  input  wire logic                            queue_full,
  input  wire logic                            clearing,
  output logic                                 push,
  output tspcm_pkg::cmd_t                      push_cmd
);

  localparam logic [tspcm_pkg::PID_WIDTH:0] PID_LIMIT = (tspcm_pkg::PID_WIDTH + 1)'(PID_SPACE);

  logic af_disc;

  // Hold off new beats while the queue is full or the tables are being cleared.
  assign in_stall = queue_full || clearing;
  assign push     = in_valid && !in_stall;

  // The discontinuity indicator counts only when an adaptation field of nonzero length is present.
  assign af_disc = afc[tspcm_pkg::AFC_FIELD_BIT] && afc[tspcm_pkg::AFC_PAYLOAD_BIT]
                   && (af_length != 8'd0) && af_flags[tspcm_pkg::DISC_BIT];

  // Classify the beat into what the back has to do with it.
  always_comb begin
    push_cmd.is_packet = (op == tspcm_pkg::OP_PACKET);
    push_cmd.is_clear  = (op == tspcm_pkg::OP_CLEAR);
    push_cmd.header_ok = (op == tspcm_pkg::OP_PACKET) && (sync_byte == tspcm_pkg::SYNC_VALUE)
                         && !tei;
    push_cmd.check_cc  = afc[tspcm_pkg::AFC_PAYLOAD_BIT] && !af_disc
                         && (pid != tspcm_pkg::NULL_PID);
    push_cmd.in_table  = ({1'b0, pid} < PID_LIMIT);
    push_cmd.pid       = pid;
    push_cmd.cc        = cc;
  end

endmodule

`default_nettype wire

[rtl/tspcm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tspcm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tspcm_pkg::cmd_t push_cmd,
  input  wire logic            pop,
  output logic                 head_valid,
  output tspcm_pkg::cmd_t      head_cmd,
  output logic                 full
);

  localparam int DEPTH     = tspcm_pkg::QUEUE_DEPTH;
  localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);

  tspcm_pkg::cmd_t        entries [DEPTH];
  logic [PTR_WIDTH-1:0]   wr_ptr;
  logic [PTR_WIDTH-1:0]   rd_ptr;
  logic [CNT_WIDTH-1:0]   count;

  assign head_valid = (count != '0);
  assign full       = (count == CNT_WIDTH'(DEPTH));
  assign head_cmd   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tspcm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tspcm_back #(
  parameter int PID_SPACE   = tspcm_pkg::PID_SPACE_DEFAULT,
  parameter int COUNT_WIDTH = tspcm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write_en,
  input  wire logic                            cfg_write_data,
  input  wire logic                            head_valid,
  input  wire tspcm_pkg::cmd_t                 head_cmd,
  output logic                                 pop,
  output logic                                 clearing,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 header_ok,
  output logic                                 discontinuity,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      pid_packet_count,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      pid_error_count,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      total_packets,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      bad_packets,
  output logic [tspcm_pkg::OUT_WIDTH-1:0]      discontinuities
);

  localparam int IDX_WIDTH   = $clog2(PID_SPACE);
  localparam int CC_W        = tspcm_pkg::CC_WIDTH;
  localparam int OUT_W       = tspcm_pkg::OUT_WIDTH;
  localparam int ENTRY_WIDTH = 1 + CC_W + 2 * COUNT_WIDTH;

  // Per-PID table: seen flag, last counter, packet count, error count.
  logic [ENTRY_WIDTH-1:0]  pid_mem [PID_SPACE];
  logic [ENTRY_WIDTH-1:0]  rd_entry;
  logic                    mem_we;
  logic [IDX_WIDTH-1:0]    mem_waddr;
  logic [ENTRY_WIDTH-1:0]  mem_wdata;

  logic                    pid_count_enable;
  logic [IDX_WIDTH-1:0]    clear_addr;

  logic                    held_valid;
  tspcm_pkg::cmd_t         held_cmd;
  logic                    exec;

  logic                    prev_seen;
  logic [CC_W-1:0]         prev_cc;
  logic [COUNT_WIDTH-1:0]  prev_packets;
  logic [COUNT_WIDTH-1:0]  prev_errors;
  logic                    update;
  logic                    mismatch;
  logic                    show_pid;
  logic [COUNT_WIDTH-1:0]  packets_next;
  logic [COUNT_WIDTH-1:0]  errors_next;

  logic [COUNT_WIDTH-1:0]  packet_total;
  logic [COUNT_WIDTH-1:0]  bad_total;
  logic [COUNT_WIDTH-1:0]  discontinuity_total;
  logic [COUNT_WIDTH-1:0]  packet_total_next;
  logic [COUNT_WIDTH-1:0]  bad_total_next;
  logic [COUNT_WIDTH-1:0]  discontinuity_total_next;

  // Low output bits of a counter, zero-extended when the counter is narrow.
  function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, v};
    return w[OUT_W-1:0];
  endfunction

  // Enable register; turning counting on starts a clearing sweep of the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      pid_count_enable <= 1'b0;
      clearing         <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        pid_count_enable <= cfg_write_data;
      end
      if (cfg_write_en && cfg_write_data && !pid_count_enable) begin
        clearing <= 1'b1;
      end else if (clearing && (clear_addr == IDX_WIDTH'(PID_SPACE - 1))) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_write_en && cfg_write_data && !pid_count_enable) begin
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  // An item is taken from the queue only when the execute slot is empty,
  // so its table write never meets the next item's read.
  assign pop  = head_valid && !held_valid && !clearing;
  assign exec = held_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (pop) begin
      held_valid <= 1'b1;
    end else if (exec) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held_cmd <= head_cmd;
    end
  end

  // Table read port: the entry of the popped item's PID.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_entry <= pid_mem[head_cmd.pid[IDX_WIDTH-1:0]];
    end
  end

  // Continuity check and per-PID counts of the held item.
  assign prev_seen    = rd_entry[ENTRY_WIDTH-1];
  assign prev_cc      = rd_entry[ENTRY_WIDTH-2 -: CC_W];
  assign prev_packets = rd_entry[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign prev_errors  = rd_entry[COUNT_WIDTH-1:0];

  assign show_pid = pid_count_enable && held_cmd.in_table;
  assign update   = show_pid && held_cmd.header_ok;
  assign mismatch = update && held_cmd.check_cc && prev_seen
                    && (held_cmd.cc != CC_W'(prev_cc + 1'b1));

  assign packets_next = update   ? prev_packets + 1'b1 : prev_packets;
  assign errors_next  = mismatch ? prev_errors + 1'b1  : prev_errors;

  // Table write port: the clearing sweep or the update of the held item.
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = exec && update;
      mem_waddr = held_cmd.pid[IDX_WIDTH-1:0];
      mem_wdata = {1'b1, held_cmd.cc, packets_next, errors_next};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pid_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Global counters.
  always_comb begin
    packet_total_next        = packet_total;
    bad_total_next           = bad_total;
    discontinuity_total_next = discontinuity_total;
    if (held_cmd.is_clear) begin
      packet_total_next        = '0;
      bad_total_next           = '0;
      discontinuity_total_next = '0;
    end else if (held_cmd.is_packet) begin
      packet_total_next = packet_total + 1'b1;
      if (!held_cmd.header_ok) begin
        bad_total_next = bad_total + 1'b1;
      end
      if (mismatch) begin
        discontinuity_total_next = discontinuity_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_total        <= '0;
      bad_total           <= '0;
      discontinuity_total <= '0;
    end else if (exec) begin
      packet_total        <= packet_total_next;
      bad_total           <= bad_total_next;
      discontinuity_total <= discontinuity_total_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      header_ok        <= held_cmd.header_ok;
      discontinuity    <= mismatch;
      pid_packet_count <= show_pid ? to_out(packets_next) : '0;
      pid_error_count  <= show_pid ? to_out(errors_next) : '0;
      total_packets    <= to_out(packet_total_next);
      bad_packets      <= to_out(bad_total_next);
      discontinuities  <= to_out(discontinuity_total_next);
    end
  end

endmodule

`default_nettype wire

[rtl/tspcm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ts_pid_continuity_monitor_assert.svh"

module tspcm_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            header_ok,
  input wire logic                            discontinuity,
  input wire logic [tspcm_pkg::OUT_WIDTH-1:0] total_packets,
  input wire logic [tspcm_pkg::OUT_WIDTH-1:0] pid_packet_count
);

  // A continuity error is only ever raised by a good header.
  `TSPCM_ASSERT_NOW(a_disc_needs_ok, out_valid && discontinuity, header_ok, "discontinuity without good header")

  // A result beat held by the receiver keeps its payload.
  `TSPCM_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(total_packets) && $stable(pid_packet_count), "stalled result beat changed")

  // No result beat directly after reset.
  `TSPCM_ASSERT_RESET(a_reset_quiet, rst, !out_valid, "result beat shown after reset")

endmodule

bind ts_pid_continuity_monitor tspcm_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .header_ok        (header_ok),
  .discontinuity    (discontinuity),
  .total_packets    (total_packets),
  .pid_packet_count (pid_packet_count)
);

`default_nettype wire

[tb/ts_pid_continuity_monitor_check.sv]
`timescale 1ns / 1ps

module ts_pid_continuity_monitor_check
  import tspcm_pkg::*;
#(
  parameter int TABLE_SIZE = PID_SPACE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic                 cfg_write_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [7:0]           sync_byte,
  input  logic                 tei,
  input  logic [PID_WIDTH-1:0] pid,
  input  logic [1:0]           afc,
  input  logic [CC_WIDTH-1:0]  cc,
  input  logic [7:0]           af_length,
  input  logic [7:0]           af_flags,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 header_ok,
  input  logic                 discontinuity,
  input  logic [OUT_WIDTH-1:0] pid_packet_count,
  input  logic [OUT_WIDTH-1:0] pid_error_count,
  input  logic [OUT_WIDTH-1:0] total_packets,
  input  logic [OUT_WIDTH-1:0] bad_packets,
  input  logic [OUT_WIDTH-1:0] discontinuities,
  output int                   failures,
  output int                   pending
);

  // One result beat as the block should present it.
  typedef struct packed {
    logic                 header_ok;
    logic                 discontinuity;
    logic [OUT_WIDTH-1:0] pkt_count;
    logic [OUT_WIDTH-1:0] err_count;
    logic [OUT_WIDTH-1:0] total;
    logic [OUT_WIDTH-1:0] bad;
    logic [OUT_WIDTH-1:0] discs;
  } counts_t;

  // Shadow of the per-PID tables; bit 4 of last_cc marks a PID as seen.
  logic [CC_WIDTH:0]    last_cc   [TABLE_SIZE];
  logic [OUT_WIDTH-1:0] pid_pkts  [TABLE_SIZE];
  logic [OUT_WIDTH-1:0] pid_errs  [TABLE_SIZE];
  logic [OUT_WIDTH-1:0] total_cnt;
  logic [OUT_WIDTH-1:0] bad_cnt;
  logic [OUT_WIDTH-1:0] disc_cnt;
  logic                 counting_on;

  counts_t expected_counts[$];
  int      mismatch_count = 0;

  assign failures = mismatch_count;

  initial pending = 0;

  // Returns every PID to never seen with zero counts.
  function automatic void clear_pid_tables();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      last_cc[i]  = '0;
      pid_pkts[i] = '0;
      pid_errs[i] = '0;
    end
  endfunction

  // Applies one header beat to the shadow state and returns the result it causes.
  function automatic counts_t predict_counts(input logic [1:0] op_i,
                                             input logic [7:0] sync_i,
                                             input logic tei_i,
                                             input logic [PID_WIDTH-1:0] pid_i,
                                             input logic [1:0] afc_i,
                                             input logic [CC_WIDTH-1:0] cc_i,
                                             input logic [7:0] len_i,
                                             input logic [7:0] flags_i);
    counts_t             r;
    logic                in_table;
    logic                payload;
    logic                af_skip;
    logic [CC_WIDTH:0]   prev;
    logic [CC_WIDTH-1:0] next_cc;
    r        = '0;
    in_table = int'(pid_i) < TABLE_SIZE;
    if (op_i == OP_PACKET) begin
      total_cnt = total_cnt + 1'b1;
      if (sync_i == SYNC_VALUE && !tei_i) begin
        r.header_ok = 1'b1;
        if (counting_on && in_table) begin
          payload = afc_i[AFC_PAYLOAD_BIT];
          // A nonempty adaptation field with its discontinuity flag excuses a jump.
          af_skip = afc_i[AFC_FIELD_BIT] && afc_i[AFC_PAYLOAD_BIT] && len_i != 8'd0
                    && flags_i[DISC_BIT];
          prev    = last_cc[pid_i];
          next_cc = prev[CC_WIDTH-1:0] + 1'b1;
          pid_pkts[pid_i] = pid_pkts[pid_i] + 1'b1;
          if (payload && !af_skip && prev[CC_WIDTH] && pid_i != NULL_PID && cc_i != next_cc)
            begin
            pid_errs[pid_i] = pid_errs[pid_i] + 1'b1;
            disc_cnt        = disc_cnt + 1'b1;
            r.discontinuity = 1'b1;
          end
          last_cc[pid_i] = {1'b1, cc_i};
        end
      end else begin
        bad_cnt = bad_cnt + 1'b1;
      end
    end else if (op_i == OP_CLEAR) begin
      total_cnt = '0;
      bad_cnt   = '0;
      disc_cnt  = '0;
    end
    if (counting_on && in_table) begin
      r.pkt_count = pid_pkts[pid_i];
      r.err_count = pid_errs[pid_i];
    end
    r.total = total_cnt;
    r.bad   = bad_cnt;
    r.discs = disc_cnt;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [OUT_WIDTH-1:0] want,
                               input logic [OUT_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Watch configuration, result and header beats at every rising edge.
  always @(posedge clk) begin
    counts_t want;
    if (rst) begin
      clear_pid_tables();
      total_cnt   = '0;
      bad_cnt     = '0;
      disc_cnt    = '0;
      counting_on = 1'b0;
      expected_counts.delete();
    end else begin
      // Switching counting on wipes the tables; writing 0 keeps them.
      if (cfg_write_en) begin
        if (cfg_write_data && !counting_on)
          clear_pid_tables();
        counting_on = cfg_write_data;
      end

      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: result beat arrived with nothing expected", $time);
          mismatch_count++;
        end else begin
          want = expected_counts.pop_front();
          compare_field("header_ok", want.header_ok, header_ok);
          compare_field("discontinuity", want.discontinuity, discontinuity);
          compare_field("pid_packet_count", want.pkt_count, pid_packet_count);
          compare_field("pid_error_count", want.err_count, pid_error_count);
          compare_field("total_packets", want.total, total_packets);
          compare_field("bad_packets", want.bad, bad_packets);
          compare_field("discontinuities", want.discs, discontinuities);
        end
      end

      if (in_valid && !in_stall)
        expected_counts.push_back(predict_counts(op, sync_byte, tei, pid, afc, cc,
                                                 af_length, af_flags));
    end
    pending = expected_counts.size();
  end

endmodule

[tb/ts_pid_continuity_monitor_test.sv]
`timescale 1ns / 1ps

module ts_pid_continuity_monitor_test;

  import tspcm_pkg::*;

  // The unused op code behaves as a query.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int STREAMS        = 8;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 50000;

  typedef struct packed {
    logic [1:0]           op;
    logic [7:0]           sync;
    logic                 tei;
    logic [PID_WIDTH-1:0] pid;
    logic [1:0]           afc;
    logic [CC_WIDTH-1:0]  cc;
    logic [7:0]           af_len;
    logic [7:0]           af_flags;
  } header_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic                 cfg_write_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           op = '0;
  logic [7:0]           sync_byte = '0;
  logic                 tei = 1'b0;
  logic [PID_WIDTH-1:0] pid = '0;
  logic [1:0]           afc = '0;
  logic [CC_WIDTH-1:0]  cc = '0;
  logic [7:0]           af_length = '0;
  logic [7:0]           af_flags = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 header_ok;
  logic                 discontinuity;
  logic [OUT_WIDTH-1:0] pid_packet_count;
  logic [OUT_WIDTH-1:0] pid_error_count;
  logic [OUT_WIDTH-1:0] total_packets;
  logic [OUT_WIDTH-1:0] bad_packets;
  logic [OUT_WIDTH-1:0] discontinuities;

  int failures;
  int pending;
  int send_idle_pct = 35;
  int recv_idle_pct = 88;
  int quiet_cycles  = 0;
  bit hold_request  = 1'b0;

  // PIDs that carry well-formed streams and the last counter sent on each.
  logic [PID_WIDTH-1:0] stream_pid [STREAMS];
  logic [CC_WIDTH-1:0]  stream_cc  [STREAMS];

  ts_pid_continuity_monitor uut (.*);

  ts_pid_continuity_monitor_check count_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, with one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic header_t build_header(input logic [1:0] op_i, input logic [7:0] sync_i,
                                           input logic tei_i, input logic [PID_WIDTH-1:0] pid_i,
                                           input logic [1:0] afc_i,
                                           input logic [CC_WIDTH-1:0] cc_i,
                                           input logic [7:0] len_i, input logic [7:0] flags_i);
    header_t h;
    h = '{op_i, sync_i, tei_i, pid_i, afc_i, cc_i, len_i, flags_i};
    return h;
  endfunction

  // Mostly well-formed streams on a few PIDs, with noise, queries and clears mixed in.
  function automatic header_t random_header();
    header_t     h;
    logic [63:0] noise;
    int          pick;
    int          slot;
    noise = {$urandom, $urandom};
    h     = noise[$bits(header_t)-1:0];
    pick  = $urandom_range(99);
    slot  = $urandom_range(STREAMS - 1);
    if (pick < 70) begin
      h.op   = OP_PACKET;
      h.sync = SYNC_VALUE;
      h.tei  = 1'b0;
      h.pid  = stream_pid[slot];
      h.afc[AFC_PAYLOAD_BIT] = ($urandom_range(9) != 0);
      if ($urandom_range(99) < 85)
        h.cc = stream_cc[slot] + 1'b1;
      if ($urandom_range(3) == 0)
        h.af_len = 8'd0;
      stream_cc[slot] = h.cc;
    end else if (pick < 78) begin
      h.op = OP_PACKET;
      if ($urandom_range(3) == 0)
        h.sync = SYNC_VALUE;
    end else if (pick < 88) begin
      h.op = ($urandom_range(4) == 0) ? OP_SPARE : OP_QUERY;
      if ($urandom_range(3) != 0)
        h.pid = stream_pid[slot];
    end else if (pick < 91) begin
      h.op = OP_CLEAR;
    end else begin
      h.op   = OP_PACKET;
      h.sync = SYNC_VALUE;
      h.tei  = 1'b0;
    end
    return h;
  endfunction

  // Offer one header beat and hold it until it is taken; each cycle before it
  // the sender may idle.
  task automatic send_header(input header_t h);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= h.op;
    sync_byte <= h.sync;
    tei       <= h.tei;
    pid       <= h.pid;
    afc       <= h.afc;
    cc        <= h.cc;
    af_length <= h.af_len;
    af_flags  <= h.af_flags;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_counting(input logic value);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_header(random_header());
  endtask

  initial begin
    stream_pid = '{13'd0, NULL_PID, 13'd17, 13'h0abc, 13'h1555, 13'h0fff, 13'h1000, 13'h0421};
    foreach (stream_cc[i])
      stream_cc[i] = CC_WIDTH'($urandom);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Per-PID counting off after reset: only the global counts move.
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'd0, 2'd1, 4'd0, 8'd0, 8'd0));
    send_header(build_header(OP_PACKET, 8'h00, 1'b0, NULL_PID, 2'd3, 4'd15, 8'hff, 8'hff));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b1, 13'd5, 2'd1, 4'd1, 8'd0, 8'd0));
    send_header(build_header(OP_QUERY, 8'h00, 1'b0, 13'd0, 2'd0, 4'd0, 8'd0, 8'd0));

    // Counting on: first sighting, wrap of the counter, a jump, a zero-length
    // adaptation field that still gets checked, a flagged jump that is excused,
    // headers without payload, the null PID, a bad header, queries and a clear.
    write_counting(1'b1);
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'h100, 2'd1, 4'd15, 8'd0, 8'd0));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'h100, 2'd1, 4'd0, 8'd0, 8'd0));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'h100, 2'd1, 4'd5, 8'd0, 8'd0));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'h100, 2'd3, 4'd9, 8'd0, 8'h80));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'h100, 2'd3, 4'd2, 8'd7, 8'h80));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'h100, 2'd0, 4'd12, 8'd0, 8'd0));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'h100, 2'd2, 4'd3, 8'd1, 8'h7f));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'h100, 2'd1, 4'd7, 8'd0, 8'd0));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, NULL_PID, 2'd1, 4'd0, 8'd0, 8'd0));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, NULL_PID, 2'd1, 4'd9, 8'd0, 8'd0));
    send_header(build_header(OP_PACKET, 8'hff, 1'b0, 13'h100, 2'd1, 4'd8, 8'd0, 8'd0));
    send_header(build_header(OP_QUERY, SYNC_VALUE, 1'b1, 13'h100, 2'd3, 4'd15, 8'hff, 8'hff));
    send_header(build_header(OP_SPARE, SYNC_VALUE, 1'b0, 13'h100, 2'd1, 4'd0, 8'd0, 8'd0));
    send_header(build_header(OP_CLEAR, 8'hb8, 1'b1, 13'h100, 2'd2, 4'd10, 8'h55, 8'haa));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'd0, 2'd1, 4'd4, 8'd0, 8'd0));
    send_header(build_header(OP_QUERY, 8'h00, 1'b0, 13'd0, 2'd0, 4'd0, 8'd0, 8'd0));

    // Counting off again: the tables are kept but hidden, and no check is made.
    write_counting(1'b0);
    send_header(build_header(OP_QUERY, 8'h00, 1'b0, 13'h100, 2'd0, 4'd0, 8'd0, 8'd0));
    send_header(build_header(OP_PACKET, SYNC_VALUE, 1'b0, 13'h100, 2'd1, 4'd1, 8'd0, 8'd0));

    // Sender mostly busy, receiver mostly stalled.
    write_counting(1'b1);
    send_random(200);

    // The other way round; counting stays on and the tables survive a repeat write.
    send_idle_pct = 88;
    recv_idle_pct = 35;
    write_counting(1'b1);
    send_random(100);
    wait_drained();
    send_random(100);

    // No idling; a stretch with counting off, then a fresh table. The long
    // hold-off starts once the clearing sweep is over, so the queue fills.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_counting(1'b0);
    send_random(40);
    write_counting(1'b1);
    send_random(10);
    hold_request = 1'b1;
    send_random(150);

    wait_drained();
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
